FILE: rtl/rsms_pkg.sv
// ----------------------------------------------------------------------------
// rsms_pkg: shared types and constants of the sorted mask set
// Item formats, command and status codes, cell shift commands and sizes.
// ----------------------------------------------------------------------------
package rsms_pkg;

  localparam int MaxValue   = 128;
  localparam int CountBits  = 16;
  localparam int Depth      = MaxValue + 1;
  localparam int AddrBits   = $clog2(Depth);
  localparam int ListBits   = $clog2(Depth + 1);
  localparam int ValueBits  = 8;
  localparam int IndexBits  = 8;
  localparam int RefBits    = 16;
  localparam int CntOutBits = 8;
  localparam int SubBits    = 4;
  localparam int GrpSize    = 1 << SubBits;
  localparam int NumGrp     = (Depth + GrpSize - 1) / GrpSize;
  localparam int GrpBits    = (NumGrp > 1) ? $clog2(NumGrp) : 1;
  localparam int PadDepth   = NumGrp * GrpSize;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } rsms_cmd_e;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_RAISED    = 4'd1,
    ST_REMOVED   = 4'd2,
    ST_LOWERED   = 4'd3,
    ST_ABSENT    = 4'd4,
    ST_INVALID   = 4'd5,
    ST_READ_OK   = 4'd6,
    ST_READ_OOR  = 4'd7,
    ST_SATURATED = 4'd8
  } rsms_status_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } rsms_shift_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ValueBits-1:0] value;
    logic [IndexBits-1:0] index;
  } rsms_in_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [CntOutBits-1:0] list_count;
    logic [ValueBits-1:0]  read_value;
    logic [RefBits-1:0]    value_refs;
  } rsms_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    rsms_shift_e          op;
    logic [ValueBits-1:0] value;
  } rsms_shift_t;

endpackage

FILE: rtl/refcounted_sorted_mask_set.sv
// ----------------------------------------------------------------------------
// refcounted_sorted_mask_set: reference counted sorted set of mask lengths
// Keeps the distinct mask lengths in use as a descending list with a count
// per value; supports insert, remove and indexed read.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start while busy is low; the item is taken at that
//   clock edge. Exactly one result follows on result_o, marked by done_o for
//   a single cycle. There is no back pressure: the receiver must take it.
//   Insert, remove, invalid commands and out-of-range reads: the result
//   is registered from the execute state and is taken at the next edge,
//   where a new item may already be started; busy falls as the result shows.
//   In-range reads: busy stays high until the result shows. The read goes
//   through a registered 16-way group select, a group pick, then one count
//   memory read.
//   The list lives in a chain of cells, one entry each; an insert or remove
//   shifts all cells together. Counts live in a memory indexed by value,
//   read in the cycle before the update.
//   Reset empties the list and zeroes all counts at once (valid bits on the
//   count memory), so items can be started right after reset.
// ----------------------------------------------------------------------------
module refcounted_sorted_mask_set import rsms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  rsms_in_t  item_i,
  output logic      done_o,
  output rsms_out_t result_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RGRP = 3'd2;
  localparam logic [2:0] S_RSEL = 3'd3;
  localparam logic [2:0] S_RCNT = 3'd4;

  logic [2:0]          state_q, state_d;
  rsms_in_t            item_q;
  logic [ListBits-1:0] used_q, used_d;
  rsms_out_t           res_q, res_d;
  logic                done_q, done_d;
  logic                accept;

  // Cell chain wiring
  rsms_shift_t          shift;
  logic [ValueBits-1:0] cell_val [Depth];
  logic [Depth-1:0]     cell_occ;
  logic [Depth-1:0]     cell_gt;

  // Read path
  logic [ValueBits-1:0] pad_val [PadDepth];
  logic [ValueBits-1:0] grp_q   [NumGrp];
  logic [ValueBits-1:0] grp_d   [NumGrp];
  logic [ValueBits-1:0] rd_sel;
  logic [ValueBits-1:0] rd_q;

  // Count memory
  logic [AddrBits-1:0]  cnt_rd_addr;
  logic                 cnt_wr_en;
  logic [CountBits-1:0] cnt_wr_data;
  logic [CountBits-1:0] cnt_rd;
  logic                 value_bad;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // ---- List cells: head sees a virtual "greater" left neighbor ----
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueBits-1:0] lv, rv;
    logic                 lo, lg, ro;
    if (i == 0) begin : g_head
      assign lv = '0;
      assign lo = 1'b1;
      assign lg = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_body
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    rsms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .left_val_i (lv),
      .left_occ_i (lo),
      .left_gt_i  (lg),
      .right_val_i(rv),
      .right_occ_i(ro),
      .val_o      (cell_val[i]),
      .occ_o      (cell_occ[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // ---- Read tree: pad the list to whole groups of 16 ----
  for (genvar j = 0; j < PadDepth; j++) begin : g_pad
    if (j < Depth) begin : g_real
      assign pad_val[j] = cell_val[j];
    end else begin : g_zero
      assign pad_val[j] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = pad_val[{GrpBits'(g), item_q.index[SubBits-1:0]}];
    end
  end

  assign rd_sel = grp_q[item_q.index[SubBits +: GrpBits]];

  always_ff @(posedge clk_i) begin
    if (state_q == S_RGRP) begin
      grp_q <= grp_d;
    end
    if (state_q == S_RSEL) begin
      rd_q <= rd_sel;
    end
    if (accept) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  // ---- Count memory: look up the value on accept, the read value later ----
  assign cnt_rd_addr = (state_q == S_RSEL) ? AddrBits'(rd_sel) : AddrBits'(item_i.value);

  rsms_count_store u_count_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(cnt_rd_addr),
    .wr_en_i  (cnt_wr_en),
    .wr_addr_i(AddrBits'(item_q.value)),
    .wr_data_i(cnt_wr_data),
    .rd_data_o(cnt_rd)
  );

  assign value_bad = (item_q.value > ValueBits'(MaxValue));

  // ---- Sequencer ----
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    done_d      = 1'b0;
    res_d       = res_q;
    cnt_wr_en   = 1'b0;
    cnt_wr_data = cnt_rd;
    shift.op    = SH_HOLD;
    shift.value = item_q.value;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // in-range reads take the long path through the read tree
          if ((item_i.cmd == CMD_READ) && (ListBits'(item_i.index) < used_q)
              && (item_i.index < IndexBits'(Depth))) begin
            state_d = S_RGRP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d             = S_IDLE;
        done_d              = 1'b1;
        res_d.status        = ST_INVALID;
        res_d.read_value    = '0;
        res_d.value_refs    = '0;
        if (item_q.cmd inside {CMD_INSERT, CMD_REMOVE} && !value_bad) begin
          if (item_q.cmd == CMD_INSERT) begin
            if (cnt_rd == '0) begin
              // new value: open a slot at its sorted place
              shift.op         = SH_INSERT;
              cnt_wr_en        = 1'b1;
              cnt_wr_data      = CountBits'(1);
              used_d           = used_q + ListBits'(1);
              res_d.status     = ST_ADDED;
              res_d.value_refs = RefBits'(1);
            end else if (cnt_rd == CountMax) begin
              res_d.status     = ST_SATURATED;
              res_d.value_refs = RefBits'(cnt_rd);
            end else begin
              cnt_wr_en        = 1'b1;
              cnt_wr_data      = cnt_rd + CountBits'(1);
              res_d.status     = ST_RAISED;
              res_d.value_refs = RefBits'(cnt_rd + CountBits'(1));
            end
          end else begin
            if (cnt_rd == '0) begin
              res_d.status = ST_ABSENT;
            end else if (cnt_rd == CountBits'(1)) begin
              // last reference: close the gap
              shift.op     = SH_REMOVE;
              cnt_wr_en    = 1'b1;
              cnt_wr_data  = '0;
              used_d       = used_q - ListBits'(1);
              res_d.status = ST_REMOVED;
            end else begin
              cnt_wr_en        = 1'b1;
              cnt_wr_data      = cnt_rd - CountBits'(1);
              res_d.status     = ST_LOWERED;
              res_d.value_refs = RefBits'(cnt_rd - CountBits'(1));
            end
          end
        end else if (item_q.cmd == CMD_READ) begin
          res_d.status = ST_READ_OOR;
        end
        res_d.list_count = CntOutBits'(used_d);
      end
      S_RGRP: begin
        state_d = S_RSEL;
      end
      S_RSEL: begin
        state_d = S_RCNT;
      end
      S_RCNT: begin
        state_d          = S_IDLE;
        done_d           = 1'b1;
        res_d.status     = ST_READ_OK;
        res_d.list_count = CntOutBits'(used_q);
        res_d.read_value = rd_q;
        res_d.value_refs = RefBits'(cnt_rd);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/rsms_cell.sv
// ----------------------------------------------------------------------------
// rsms_cell: one slot of the sorted list
// Holds one entry and its occupied flag; on insert or remove it takes the
// new value or the entry of a neighbor, so the list stays sorted descending.
// ----------------------------------------------------------------------------
module rsms_cell import rsms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsms_shift_t          shift_i,
  input  logic [ValueBits-1:0] left_val_i,
  input  logic                 left_occ_i,
  input  logic                 left_gt_i,
  input  logic [ValueBits-1:0] right_val_i,
  input  logic                 right_occ_i,
  output logic [ValueBits-1:0] val_o,
  output logic                 occ_o,
  output logic                 gt_o
);

  logic [ValueBits-1:0] val_q, val_d;
  logic                 occ_q, occ_d;
  logic                 gt;

  // Entry is larger than the value on the broadcast.
  assign gt = occ_q && (val_q > shift_i.value);

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    case (shift_i.op)
      SH_INSERT: begin
        if (!gt) begin
          val_d = left_gt_i ? shift_i.value : left_val_i;
          occ_d = occ_q | left_occ_i;
        end
      end
      SH_REMOVE: begin
        if (!gt) begin
          val_d = right_val_i;
          occ_d = right_occ_i;
        end
      end
      default: begin
        val_d = val_q;
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;
  assign gt_o  = gt;

endmodule

FILE: rtl/rsms_count_store.sv
// ----------------------------------------------------------------------------
// rsms_count_store: reference count memory
// One count per value, one write and one registered read per cycle; a valid
// bit per entry makes unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rsms_count_store import rsms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AddrBits-1:0]  rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AddrBits-1:0]  wr_addr_i,
  input  logic [CountBits-1:0] wr_data_i,
  output logic [CountBits-1:0] rd_data_o
);

  logic [CountBits-1:0] mem [Depth];
  logic [Depth-1:0]     valid_q;
  logic [CountBits-1:0] data_q;
  logic                 vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = vld_q ? data_q : '0;

endmodule
